// ----- design/pfb2pfa_pkg.sv -----
`timescale 1ns / 1ps
// Package for the segmented binary font to ASCII hex converter.
// Holds the transaction payload types, the status and segment codes and the hex digit helper.
package pfb2pfa_pkg;

   localparam int unsigned MAX_RESULTS = 3;

   localparam logic [7:0] MARKER_BYTE  = 8'h80;
   localparam logic [7:0] CR_CHAR      = 8'd13;
   localparam logic [7:0] LF_CHAR      = 8'd10;
   localparam logic [7:0] LIMIT_RESET  = 8'd76;

   localparam logic [7:0] SEG_ASCII    = 8'd1;
   localparam logic [7:0] SEG_BINARY   = 8'd2;
   localparam logic [7:0] SEG_END      = 8'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_FIRST = 3'd1;
   localparam logic [2:0] ST_PREMATURE = 3'd2;
   localparam logic [2:0] ST_UNKNOWN   = 3'd3;
   localparam logic [2:0] ST_BAD_MARK  = 3'd4;
   localparam logic [2:0] ST_DONE      = 3'd5;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic [2:0] status;
      logic       last;
   } rsp_type;

   typedef struct packed {
      rsp_type [MAX_RESULTS-1:0] res;
      logic [1:0]                count;
   } batch_type;

   function automatic rsp_type make_rsp(input logic [7:0] ch, input logic valid,
                                        input logic [2:0] st);
      rsp_type r;
      r.out_char   = ch;
      r.char_valid = valid;
      r.status     = st;
      r.last       = 1'b0;
      return r;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = 8'h30 + {4'd0, nib};
      end else begin
         c = 8'h37 + {4'd0, nib};
      end
      return c;
   endfunction

endpackage

// ----- design/pfb2pfa_core.sv -----
`timescale 1ns / 1ps
// Input register, segment parser state and result generation for one transaction.
// Depends on pfb2pfa_pkg; hands a batch of up to three results to pfb2pfa_rsp_queue.
module pfb2pfa_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pfb2pfa_pkg::req_type  req_data,
   input  logic                  csr_wr_en,
   input  logic [7:0]            csr_wr_data,
   output logic                  batch_valid,
   input  logic                  batch_ready,
   output pfb2pfa_pkg::batch_type batch
);

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_TYPE,
      PH_LENGTH,
      PH_DATA,
      PH_MARKER
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [1:0]           seg_type_ff, seg_type_in;
   logic [31:0]          bytes_left_ff, bytes_left_in;
   logic [1:0]           len_idx_ff, len_idx_in;
   logic [7:0]           hex_col_ff, hex_col_in;
   logic                 halted_ff, halted_in;
   logic [7:0]           limit_ff;
   logic                 in_valid_ff;
   pfb2pfa_pkg::req_type in_data_ff;
   logic                 take;
   logic [7:0]           b;
   logic                 eoi;
   logic [31:0]          len_full;
   logic [8:0]           col;

   assign take      = in_valid_ff && batch_ready;
   assign req_ready = !in_valid_ff || batch_ready;
   assign b         = in_data_ff.in_byte;
   assign eoi       = in_data_ff.end_of_input;

   always_comb begin
      phase_in      = phase_ff;
      seg_type_in   = seg_type_ff;
      bytes_left_in = bytes_left_ff;
      len_idx_in    = len_idx_ff;
      hex_col_in    = hex_col_ff;
      halted_in     = halted_ff;
      batch         = '0;
      len_full      = bytes_left_ff;
      len_full[{len_idx_ff, 3'b000} +: 8] = bytes_left_ff[{len_idx_ff, 3'b000} +: 8] | b;
      col           = {1'b0, hex_col_ff} + 9'd2;
      if (!halted_ff) begin
         unique case (phase_ff)
            PH_FIRST: begin
               if (eoi || b != pfb2pfa_pkg::MARKER_BYTE) begin
                  halted_in    = 1'b1;
                  batch.res[0] = pfb2pfa_pkg::make_rsp(8'd0, 1'b0, pfb2pfa_pkg::ST_BAD_FIRST);
                  batch.count  = 2'd1;
               end else begin
                  phase_in = PH_TYPE;
               end
            end
            PH_TYPE: begin
               if (eoi) begin
                  halted_in    = 1'b1;
                  batch.res[0] = pfb2pfa_pkg::make_rsp(pfb2pfa_pkg::LF_CHAR, 1'b1,
                                                       pfb2pfa_pkg::ST_PREMATURE);
                  batch.count  = 2'd1;
               end else if (b == pfb2pfa_pkg::SEG_ASCII || b == pfb2pfa_pkg::SEG_BINARY) begin
                  seg_type_in   = b[1:0];
                  bytes_left_in = '0;
                  len_idx_in    = '0;
                  phase_in      = PH_LENGTH;
               end else if (b == pfb2pfa_pkg::SEG_END) begin
                  halted_in    = 1'b1;
                  batch.res[0] = pfb2pfa_pkg::make_rsp(pfb2pfa_pkg::LF_CHAR, 1'b1,
                                                       pfb2pfa_pkg::ST_DONE);
                  batch.count  = 2'd1;
               end else begin
                  phase_in     = PH_MARKER;
                  batch.res[0] = pfb2pfa_pkg::make_rsp(8'd0, 1'b0, pfb2pfa_pkg::ST_UNKNOWN);
                  batch.count  = 2'd1;
               end
            end
            PH_LENGTH: begin
               if (eoi) begin
                  halted_in    = 1'b1;
                  batch.res[0] = pfb2pfa_pkg::make_rsp(pfb2pfa_pkg::LF_CHAR, 1'b1,
                                                       pfb2pfa_pkg::ST_PREMATURE);
                  batch.count  = 2'd1;
               end else begin
                  bytes_left_in = len_full;
                  if (len_idx_ff != 2'd3) begin
                     len_idx_in = len_idx_ff + 2'd1;
                  end else begin
                     len_idx_in = '0;
                     phase_in   = (len_full != '0) ? PH_DATA : PH_MARKER;
                     if (seg_type_ff == pfb2pfa_pkg::SEG_BINARY[1:0]) begin
                        hex_col_in   = '0;
                        batch.res[0] = pfb2pfa_pkg::make_rsp(pfb2pfa_pkg::LF_CHAR, 1'b1,
                                                             pfb2pfa_pkg::ST_OK);
                        batch.count  = 2'd1;
                     end
                  end
               end
            end
            PH_DATA: begin
               if (eoi) begin
                  halted_in    = 1'b1;
                  batch.res[0] = pfb2pfa_pkg::make_rsp(pfb2pfa_pkg::LF_CHAR, 1'b1,
                                                       pfb2pfa_pkg::ST_PREMATURE);
                  batch.count  = 2'd1;
               end else begin
                  if (seg_type_ff == pfb2pfa_pkg::SEG_BINARY[1:0]) begin
                     batch.res[0] = pfb2pfa_pkg::make_rsp(pfb2pfa_pkg::hex_char(b[7:4]), 1'b1,
                                                          pfb2pfa_pkg::ST_OK);
                     batch.res[1] = pfb2pfa_pkg::make_rsp(pfb2pfa_pkg::hex_char(b[3:0]), 1'b1,
                                                          pfb2pfa_pkg::ST_OK);
                     if (col >= {1'b0, limit_ff}) begin
                        batch.res[2] = pfb2pfa_pkg::make_rsp(pfb2pfa_pkg::LF_CHAR, 1'b1,
                                                             pfb2pfa_pkg::ST_OK);
                        batch.count  = 2'd3;
                        hex_col_in   = '0;
                     end else begin
                        batch.count  = 2'd2;
                        hex_col_in   = col[7:0];
                     end
                  end else begin
                     batch.res[0] = pfb2pfa_pkg::make_rsp(
                        (b == pfb2pfa_pkg::CR_CHAR) ? pfb2pfa_pkg::LF_CHAR : b, 1'b1,
                        pfb2pfa_pkg::ST_OK);
                     batch.count  = 2'd1;
                  end
                  bytes_left_in = bytes_left_ff - 32'd1;
                  if (bytes_left_ff == 32'd1) begin
                     phase_in = PH_MARKER;
                  end
               end
            end
            PH_MARKER: begin
               if (eoi) begin
                  halted_in    = 1'b1;
                  batch.res[0] = pfb2pfa_pkg::make_rsp(pfb2pfa_pkg::LF_CHAR, 1'b1,
                                                       pfb2pfa_pkg::ST_DONE);
                  batch.count  = 2'd1;
               end else if (b != pfb2pfa_pkg::MARKER_BYTE) begin
                  halted_in    = 1'b1;
                  batch.res[0] = pfb2pfa_pkg::make_rsp(pfb2pfa_pkg::LF_CHAR, 1'b1,
                                                       pfb2pfa_pkg::ST_BAD_MARK);
                  batch.count  = 2'd1;
               end else begin
                  phase_in = PH_TYPE;
               end
            end
            default: begin
               phase_in = PH_FIRST;
            end
         endcase
      end
      if (batch.count != 2'd0) begin
         batch.res[batch.count - 2'd1].last = 1'b1;
      end
   end

   assign batch_valid = take && (batch.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         phase_ff      <= PH_FIRST;
         seg_type_ff   <= '0;
         bytes_left_ff <= '0;
         len_idx_ff    <= '0;
         hex_col_ff    <= '0;
         halted_ff     <= 1'b0;
         limit_ff      <= pfb2pfa_pkg::LIMIT_RESET;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (take) begin
            phase_ff      <= phase_in;
            seg_type_ff   <= seg_type_in;
            bytes_left_ff <= bytes_left_in;
            len_idx_ff    <= len_idx_in;
            hex_col_ff    <= hex_col_in;
            halted_ff     <= halted_in;
         end
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

`ifndef ASSERT_OFF
   a_halted_silent: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !batch_valid)
      else $error("halted converter produced results");
   a_halted_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted flag cleared without reset");
   a_hex_col_bound: assert property (@(posedge clock) disable iff (reset)
      take && phase_ff == PH_DATA && !halted_ff && !eoi
      && seg_type_ff == pfb2pfa_pkg::SEG_BINARY[1:0] |=> hex_col_ff < 8'd255)
      else $error("hex column out of range");
`endif

endmodule

// ----- design/pfb2pfa_rsp_queue.sv -----
`timescale 1ns / 1ps
// Result buffer that takes a batch of up to three results and presents them one per cycle while rsp_ready is high.
// Depends on pfb2pfa_pkg for the batch and result types.
module pfb2pfa_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   batch_valid,
   output logic                   batch_ready,
   input  pfb2pfa_pkg::batch_type batch,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pfb2pfa_pkg::rsp_type   rsp_data
);

   pfb2pfa_pkg::rsp_type [pfb2pfa_pkg::MAX_RESULTS-1:0] entry_ff;
   logic [1:0]                                         cnt_ff;
   logic                                               pop;

   assign rsp_valid   = cnt_ff != 2'd0;
   assign rsp_data    = entry_ff[0];
   assign pop         = rsp_valid && rsp_ready;
   assign batch_ready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (batch_valid && batch_ready) begin
         cnt_ff <= batch.count;
      end else if (pop) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (batch_valid && batch_ready) begin
         entry_ff <= batch.res;
      end else if (pop) begin
         entry_ff[0] <= entry_ff[1];
         entry_ff[1] <= entry_ff[2];
      end
   end

`ifndef ASSERT_OFF
   a_last_on_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cnt_ff == 2'd1 |-> rsp_data.last)
      else $error("final buffered result lacks last");
   a_no_early_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cnt_ff > 2'd1 |-> !rsp_data.last)
      else $error("last flagged before the final result");
   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      batch_valid && batch_ready |=> cnt_ff != 2'd0)
      else $error("loaded batch left buffer empty");
`endif

endmodule

// ----- design/pfb_to_pfa_converter.sv -----
`timescale 1ns / 1ps
// Segmented binary font to ASCII hex converter, top level.
// A transaction passes the input register of pfb2pfa_core; its results then pass the
// result buffer of pfb2pfa_rsp_queue before they are offered on the result port.
// Throughput: one input transaction per cycle while each yields at most one result and
// rsp_ready is high; a transaction with two or three results holds the single port longer.
// Reset is synchronous and active high; it clears parser state and sets the line limit to 76.
module pfb_to_pfa_converter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pfb2pfa_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pfb2pfa_pkg::rsp_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data
);

   logic                   batch_valid;
   logic                   batch_ready;
   pfb2pfa_pkg::batch_type batch;

   pfb2pfa_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .batch_valid (batch_valid),
      .batch_ready (batch_ready),
      .batch       (batch)
   );

   pfb2pfa_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .batch_valid (batch_valid),
      .batch_ready (batch_ready),
      .batch       (batch),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- verif/tb_pfb_to_pfa_converter.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for pfb_to_pfa_converter: feeds one segmented font file and checks
// every output character against a built-in model. Depends on pfb2pfa_pkg and the converter RTL.
module tb_pfb_to_pfa_converter;

   localparam int STALL_LIMIT = 2000;

   typedef enum logic [2:0] {
      AWAIT_FIRST,
      AWAIT_TYPE,
      AWAIT_LENGTH,
      AWAIT_DATA,
      AWAIT_MARKER
   } parse_stage_type;

   class pfa_char_board;
      pfb2pfa_pkg::rsp_type pending_chars[$];
      int                   mismatches;
      logic [7:0]           line_limit;
      parse_stage_type      stage;
      logic [7:0]           seg_kind;
      logic [31:0]          remaining;
      logic [1:0]           len_idx;
      logic [7:0]           column;
      bit                   halted;
      string                digits;

      function new();
         mismatches = 0;
         line_limit = pfb2pfa_pkg::LIMIT_RESET;
         stage      = AWAIT_FIRST;
         seg_kind   = 8'd0;
         remaining  = 32'd0;
         len_idx    = 2'd0;
         column     = 8'd0;
         halted     = 1'b0;
         digits     = "0123456789ABCDEF";
      endfunction

      function void set_line_limit(input logic [7:0] value);
         line_limit = value;
      endfunction

      function void add_char(input logic [7:0] ch, input logic valid, input logic [2:0] st);
         pfb2pfa_pkg::rsp_type r;
         r.out_char   = ch;
         r.char_valid = valid;
         r.status     = st;
         r.last       = 1'b0;
         pending_chars.push_back(r);
      endfunction

      function void close_stream(input logic [2:0] st);
         halted = 1'b1;
         add_char(pfb2pfa_pkg::LF_CHAR, 1'b1, st);
      endfunction

      function void absorb_byte(input pfb2pfa_pkg::req_type t);
         int unsigned          start_size;
         int unsigned          col;
         pfb2pfa_pkg::rsp_type tail;
         logic [7:0]           b;
         start_size = pending_chars.size();
         b = t.in_byte;
         if (!halted) begin
            case (stage)
               AWAIT_FIRST: begin
                  if (t.end_of_input || b != pfb2pfa_pkg::MARKER_BYTE) begin
                     halted = 1'b1;
                     add_char(8'd0, 1'b0, pfb2pfa_pkg::ST_BAD_FIRST);
                  end else begin
                     stage = AWAIT_TYPE;
                  end
               end
               AWAIT_TYPE: begin
                  if (t.end_of_input) begin
                     close_stream(pfb2pfa_pkg::ST_PREMATURE);
                  end else if (b == pfb2pfa_pkg::SEG_ASCII || b == pfb2pfa_pkg::SEG_BINARY) begin
                     seg_kind  = b;
                     remaining = 32'd0;
                     len_idx   = 2'd0;
                     stage     = AWAIT_LENGTH;
                  end else if (b == pfb2pfa_pkg::SEG_END) begin
                     close_stream(pfb2pfa_pkg::ST_DONE);
                  end else begin
                     stage = AWAIT_MARKER;
                     add_char(8'd0, 1'b0, pfb2pfa_pkg::ST_UNKNOWN);
                  end
               end
               AWAIT_LENGTH: begin
                  if (t.end_of_input) begin
                     close_stream(pfb2pfa_pkg::ST_PREMATURE);
                  end else begin
                     remaining = remaining | ({24'd0, b} << (8 * len_idx));
                     if (len_idx != 2'd3) begin
                        len_idx = len_idx + 2'd1;
                     end else begin
                        len_idx = 2'd0;
                        stage = (remaining != 32'd0) ? AWAIT_DATA : AWAIT_MARKER;
                        if (seg_kind == pfb2pfa_pkg::SEG_BINARY) begin
                           column = 8'd0;
                           add_char(pfb2pfa_pkg::LF_CHAR, 1'b1, pfb2pfa_pkg::ST_OK);
                        end
                     end
                  end
               end
               AWAIT_DATA: begin
                  if (t.end_of_input) begin
                     close_stream(pfb2pfa_pkg::ST_PREMATURE);
                  end else begin
                     if (seg_kind == pfb2pfa_pkg::SEG_BINARY) begin
                        col = column + 2;
                        add_char(digits[b[7:4]], 1'b1, pfb2pfa_pkg::ST_OK);
                        add_char(digits[b[3:0]], 1'b1, pfb2pfa_pkg::ST_OK);
                        if (col >= line_limit) begin
                           add_char(pfb2pfa_pkg::LF_CHAR, 1'b1, pfb2pfa_pkg::ST_OK);
                           col = 0;
                        end
                        column = 8'(col);
                     end else begin
                        add_char((b == pfb2pfa_pkg::CR_CHAR) ? pfb2pfa_pkg::LF_CHAR : b, 1'b1,
                                 pfb2pfa_pkg::ST_OK);
                     end
                     remaining = remaining - 32'd1;
                     if (remaining == 32'd0) begin
                        stage = AWAIT_MARKER;
                     end
                  end
               end
               AWAIT_MARKER: begin
                  if (t.end_of_input) begin
                     close_stream(pfb2pfa_pkg::ST_DONE);
                  end else if (b != pfb2pfa_pkg::MARKER_BYTE) begin
                     close_stream(pfb2pfa_pkg::ST_BAD_MARK);
                  end else begin
                     stage = AWAIT_TYPE;
                  end
               end
               default: begin
                  stage = AWAIT_FIRST;
               end
            endcase
         end
         if (pending_chars.size() > start_size) begin
            tail = pending_chars.pop_back();
            tail.last = 1'b1;
            pending_chars.push_back(tail);
         end
      endfunction

      function void match_char(input pfb2pfa_pkg::rsp_type got);
         pfb2pfa_pkg::rsp_type want;
         if (pending_chars.size() == 0) begin
            $error("unexpected transaction: out_char %0h char_valid %0b status %0d last %0b",
                   got.out_char, got.char_valid, got.status, got.last);
            mismatches++;
            return;
         end
         want = pending_chars.pop_front();
         if (got.out_char !== want.out_char) begin
            $error("out_char expected %0h actual %0h", want.out_char, got.out_char);
            mismatches++;
         end
         if (got.char_valid !== want.char_valid) begin
            $error("char_valid expected %0b actual %0b", want.char_valid, got.char_valid);
            mismatches++;
         end
         if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last expected %0b actual %0b", want.last, got.last);
            mismatches++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   pfb2pfa_pkg::req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   pfb2pfa_pkg::rsp_type rsp_data;
   logic                 csr_wr_en;
   logic [7:0]           csr_wr_data;

   pfa_char_board        board;
   pfb2pfa_pkg::req_type font_bytes[$];
   int unsigned          directed_count;
   int unsigned          sender_idle_pct;
   int unsigned          stall_pct;

   pfb_to_pfa_converter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void put_byte(input logic [7:0] b, input logic eoi);
      pfb2pfa_pkg::req_type t;
      t.in_byte      = b;
      t.end_of_input = eoi;
      font_bytes.push_back(t);
   endfunction

   function automatic void put_length(input logic [31:0] len);
      put_byte(len[7:0], 1'b0);
      put_byte(len[15:8], 1'b0);
      put_byte(len[23:16], 1'b0);
      put_byte(len[31:24], 1'b0);
   endfunction

   function automatic void build_font_stream();
      int unsigned pick;
      int unsigned seg_len;
      int unsigned k;
      logic [7:0]  kind;
      // Directed opening: ASCII segment with CR and extreme bytes, an unknown type,
      // an empty binary segment and a short binary segment.
      put_byte(pfb2pfa_pkg::MARKER_BYTE, 1'b0);
      put_byte(pfb2pfa_pkg::SEG_ASCII, 1'b0);
      put_length(32'd3);
      put_byte(pfb2pfa_pkg::CR_CHAR, 1'b0);
      put_byte(8'h00, 1'b0);
      put_byte(8'hFF, 1'b0);
      put_byte(pfb2pfa_pkg::MARKER_BYTE, 1'b0);
      put_byte(8'h00, 1'b0);
      put_byte(pfb2pfa_pkg::MARKER_BYTE, 1'b0);
      put_byte(pfb2pfa_pkg::SEG_BINARY, 1'b0);
      put_length(32'd0);
      put_byte(pfb2pfa_pkg::MARKER_BYTE, 1'b0);
      put_byte(pfb2pfa_pkg::SEG_BINARY, 1'b0);
      put_length(32'd2);
      put_byte(8'h00, 1'b0);
      put_byte(8'hFF, 1'b0);
      directed_count = font_bytes.size();

      while (font_bytes.size() - directed_count < 90) begin
         pick = $urandom_range(0, 9);
         put_byte(pfb2pfa_pkg::MARKER_BYTE, 1'b0);
         if (pick == 0) begin
            kind = 8'($urandom_range(0, 252));
            if (kind != 8'd0) begin
               kind = kind + 8'd3;
            end
            put_byte(kind, 1'b0);
         end else begin
            kind = (pick < 5) ? pfb2pfa_pkg::SEG_ASCII : pfb2pfa_pkg::SEG_BINARY;
            seg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(0, 10);
            put_byte(kind, 1'b0);
            put_length(seg_len);
            for (k = 0; k < seg_len; k++) begin
               if (kind == pfb2pfa_pkg::SEG_ASCII && $urandom_range(0, 7) == 0) begin
                  put_byte(pfb2pfa_pkg::CR_CHAR, 1'b0);
               end else begin
                  put_byte(8'($urandom), 1'b0);
               end
            end
         end
      end

      // The stream closes in one of the ways the format allows; only reset would revive it.
      case ($urandom_range(0, 5))
         0: begin
            put_byte(pfb2pfa_pkg::MARKER_BYTE, 1'b0);
            put_byte(pfb2pfa_pkg::SEG_END, 1'b0);
         end
         1: begin
            put_byte(8'($urandom), 1'b1);
         end
         2: begin
            put_byte(pfb2pfa_pkg::MARKER_BYTE, 1'b0);
            put_byte(8'($urandom), 1'b1);
         end
         3: begin
            put_byte(pfb2pfa_pkg::MARKER_BYTE, 1'b0);
            put_byte(8'($urandom_range(1, 2)), 1'b0);
            repeat ($urandom_range(0, 3)) put_byte(8'($urandom), 1'b0);
            put_byte(8'($urandom), 1'b1);
         end
         4: begin
            put_byte(pfb2pfa_pkg::MARKER_BYTE, 1'b0);
            put_byte(8'($urandom_range(1, 2)), 1'b0);
            put_byte(8'($urandom), 1'b0);
            put_byte(8'($urandom), 1'b0);
            put_byte(8'($urandom), 1'b0);
            put_byte(8'($urandom_range(1, 255)), 1'b0);
            repeat ($urandom_range(1, 6)) put_byte(8'($urandom), 1'b0);
            put_byte(8'($urandom), 1'b1);
         end
         default: begin
            put_byte(8'($urandom_range(0, 127)), 1'b0);
         end
      endcase
      repeat (3) put_byte(8'($urandom), 1'($urandom_range(0, 1)));
   endfunction

   task automatic send_item(input pfb2pfa_pkg::req_type item);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data  = item;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.absorb_byte(item);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      while (board.pending_chars.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_line_limit(input logic [7:0] value);
      csr_wr_data = value;
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      board.set_line_limit(value);
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.match_char(rsp_data);
      end
   end

   initial begin
      int stalled_cycles;
      stalled_cycles = 0;
      while (stalled_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stalled_cycles = 0;
         end else begin
            stalled_cycles++;
         end
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int unsigned next_idx;
      int unsigned stop_idx;
      int unsigned chunk;
      int          phase_idx;
      board           = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = 8'd0;
      sender_idle_pct = 0;
      stall_pct       = 0;
      build_font_stream();
      chunk = (font_bytes.size() - directed_count + 6) / 7;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      next_idx = 0;
      for (phase_idx = 0; phase_idx < 8; phase_idx++) begin
         if (phase_idx > 0) begin
            wait_for_drain();
            case (phase_idx)
               1: write_line_limit(8'd2);
               2: write_line_limit(8'd254);
               3: write_line_limit(8'd1);
               6: write_line_limit(pfb2pfa_pkg::LIMIT_RESET);
               default: write_line_limit(8'($urandom_range(2, 254)));
            endcase
         end
         case (phase_idx % 4)
            0: begin
               sender_idle_pct = 0;
               stall_pct       = 0;
            end
            1: begin
               sender_idle_pct = 60;
               stall_pct       = 0;
            end
            2: begin
               sender_idle_pct = 0;
               stall_pct       = 60;
            end
            default: begin
               sender_idle_pct = 26;
               stall_pct       = 26;
            end
         endcase
         stop_idx = (phase_idx == 0) ? directed_count : next_idx + chunk;
         if (phase_idx == 7 || stop_idx > font_bytes.size()) begin
            stop_idx = font_bytes.size();
         end
         while (next_idx < stop_idx) begin
            send_item(font_bytes[next_idx]);
            next_idx++;
         end
         req_valid = 1'b0;
      end

      stall_pct = 0;
      wait_for_drain();
      repeat (6) @(negedge clock);
      if (board.mismatches == 0 && board.pending_chars.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/pfb2pfa_pkg.sv
design/pfb2pfa_core.sv
design/pfb2pfa_rsp_queue.sv
design/pfb_to_pfa_converter.sv
verif/tb_pfb_to_pfa_converter.sv
